@@ rtl/core/tmsa_pkg.sv @@
// shared widths, reset values and register map of the trimmed-mean sample averager
package tmsa_pkg;

  localparam int unsigned SAMPLE_W   = 17;
  localparam int unsigned SUM_W      = 25;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned TDATA_W    = ((SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned STEP_W     = $clog2(SUM_W);

  localparam int unsigned MAX_SAMPLES_DEF = 255;
  localparam int unsigned MIN_BURST_LEN   = 3;
  localparam int unsigned TRIM_DROP       = 2;
  localparam int unsigned SPA_RESET       = 10;

  // register word index of samples_per_average
  localparam logic REG_SAMPLES_PER_AVERAGE = 1'b0;

endpackage

@@ rtl/core/trimmed_mean_sample_averager_core.sv @@
// trimmed-mean averager: sum, min, max and count per burst, serial divide at burst end
//
// Usage:
//   s_axis carries one 17-bit sample per transfer (unsigned, half-lux units).
//   m_axis carries one 17-bit trimmed average per completed burst: the burst
//   sum minus its smallest and largest sample, divided by the sample count
//   minus two, truncated.
//   The APB port holds samples_per_average at byte address 0 (reset 10).
//   Values below 3 act as 3 and values above MAX_SAMPLES act as MAX_SAMPLES.
//   The last sample of a burst is accumulated, then the sum goes through two trim
//   subtractions and 25 restoring divide steps, all through one shared 25-bit
//   add/subtract unit, and no new sample is taken until the divide is done.
//   The result register is then loaded and m_axis_tvalid rises.
//   While a result waits on a stalled receiver, samples keep being taken;
//   only the sample that would end the next burst waits for the output.
//   Reset returns the burst state to empty and the register to 10.
module trimmed_mean_sample_averager_core
  import tmsa_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // sample input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,  // [16:0] sample, rest zero
  // trimmed average output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata   // [16:0] trimmed_average, rest zero
);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_TRIM_MIN = 2'd1;
  localparam logic [1:0] ST_TRIM_MAX = 2'd2;
  localparam logic [1:0] ST_DIV      = 2'd3;

  localparam logic [CNT_W-1:0]  MaxLen   = CNT_W'(MAX_SAMPLES);
  localparam logic [CNT_W-1:0]  MinLen   = CNT_W'(MIN_BURST_LEN);
  localparam logic [CNT_W:0]    DropCnt  = (CNT_W+1)'(TRIM_DROP);
  localparam logic [STEP_W-1:0] LastStep = STEP_W'(SUM_W - 1);

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    spa_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SAMPLE_W-1:0] min_q, min_d;
  logic [SAMPLE_W-1:0] max_q, max_d;
  logic [CNT_W-1:0]    div_q, div_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_data_q, out_data_d;

  logic [CNT_W-1:0]    burst_len;
  logic [CNT_W:0]      cnt_next;
  logic                last_pending;
  logic                in_xfer;
  logic                cfg_wr;
  logic [SAMPLE_W-1:0] sample;
  logic [CNT_W:0]      rem_sh;

  // shared add/subtract unit
  logic [SUM_W-1:0]    alu_a, alu_b;
  logic                alu_sub;
  logic [SUM_W:0]      alu_res;

  assign sample = s_axis_tdata[SAMPLE_W-1:0];

  always_comb begin
    burst_len = spa_q;
    if (spa_q < MinLen) burst_len = MinLen;
    if (spa_q > MaxLen) burst_len = MaxLen;
  end

  assign cnt_next     = {1'b0, cnt_q} + (CNT_W+1)'(1);
  assign last_pending = cnt_next >= {1'b0, burst_len};
  // a burst-ending sample needs the output register free
  assign s_axis_tready = (state_q == ST_IDLE) && !(out_valid_q && last_pending);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign rem_sh = {rem_q, sum_q[SUM_W-1]};

  always_comb begin
    alu_a   = sum_q;
    alu_b   = SUM_W'(sample);
    alu_sub = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        alu_b   = SUM_W'(sample);
        alu_sub = 1'b0;
      end
      ST_TRIM_MIN: begin
        alu_b   = SUM_W'(min_q);
        alu_sub = 1'b1;
      end
      ST_TRIM_MAX: begin
        alu_b   = SUM_W'(max_q);
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = SUM_W'(rem_sh);
        alu_b   = SUM_W'(div_q);
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
    alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    min_d       = min_q;
    max_d       = max_q;
    div_d       = div_q;
    rem_d       = rem_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (m_axis_tvalid && m_axis_tready) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          sum_d = alu_res[SUM_W-1:0];
          if (cnt_q == '0) begin
            min_d = sample;
            max_d = sample;
          end else begin
            if (sample < min_q) min_d = sample;
            if (sample > max_q) max_d = sample;
          end
          if (last_pending) begin
            cnt_d   = '0;
            div_d   = CNT_W'(cnt_next - DropCnt);
            state_d = ST_TRIM_MIN;
          end else begin
            cnt_d = cnt_next[CNT_W-1:0];
          end
        end
      end
      ST_TRIM_MIN: begin
        sum_d   = alu_res[SUM_W-1:0];
        state_d = ST_TRIM_MAX;
      end
      ST_TRIM_MAX: begin
        sum_d   = alu_res[SUM_W-1:0];
        rem_d   = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // restoring step: the borrow bit says the divisor did not fit
        if (alu_res[SUM_W]) begin
          rem_d = rem_sh[CNT_W-1:0];
          sum_d = {sum_q[SUM_W-2:0], 1'b0};
        end else begin
          rem_d = alu_res[CNT_W-1:0];
          sum_d = {sum_q[SUM_W-2:0], 1'b1};
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == LastStep) begin
          out_data_d  = sum_d[SAMPLE_W-1:0];
          out_valid_d = 1'b1;
          sum_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q      <= min_d;
    max_q      <= max_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    step_q     <= step_d;
    out_data_q <= out_data_d;
  end

  // configuration register
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spa_q <= CNT_W'(SPA_RESET);
    end else if (cfg_wr && (paddr[2] == REG_SAMPLES_PER_AVERAGE)) begin
      spa_q <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SAMPLES_PER_AVERAGE) ? APB_DATA_W'(spa_q) : '0;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_data_q);

endmodule

@@ rtl/core/tmsa_checker.sv @@
// port-level checks of the trimmed-mean averager, bound to the top level
module tmsa_checker
  import tmsa_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic [APB_DATA_W-1:0] prdata,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [TDATA_W-1:0]    m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // a new result comes out of the divide, never straight from a sample transfer
  a_result_after_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) && $past(rst_ni) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared right after a sample transfer");

  // the average never exceeds the sample range
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:SAMPLE_W] == '0)
    else $error("result outside sample range");

  // burst length reads back as the low 8 bits written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[2] == REG_SAMPLES_PER_AVERAGE
    |=> !$past(rst_ni) || (paddr[2] != REG_SAMPLES_PER_AVERAGE) ||
        (prdata == APB_DATA_W'($past(pwdata[CNT_W-1:0]))))
    else $error("register readback mismatch");

endmodule

bind trimmed_mean_sample_averager_core tmsa_checker u_tmsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/sv/trimmed_mean_sample_averager_core_tb.sv @@
// self-checking testbench of the trimmed-mean sample averager core
module trimmed_mean_sample_averager_core_tb;
  import tmsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned DRAIN_CYCLES = 40;   // margin over the trim and divide steps after a last sample
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned TIMEOUT_NS   = 2_000_000;

  localparam logic [APB_ADDR_W-1:0] ADDR_BURST_LEN =
    APB_ADDR_W'(REG_SAMPLES_PER_AVERAGE) << 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED  = ADDR_BURST_LEN + 3'd4;

  // burst state of the averager and the trimmed averages still to come
  class burst_tracker;
    logic [CNT_W-1:0]    burst_reg;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [CNT_W-1:0]    taken;
    logic [SAMPLE_W-1:0] averages_due[$];
    int                  averages_checked;
    int                  errors;

    function new();
      burst_reg        = CNT_W'(SPA_RESET);
      sum              = '0;
      lo               = '0;
      hi               = '0;
      taken            = '0;
      averages_checked = 0;
      errors           = 0;
    endfunction

    function void set_burst_reg(logic [APB_DATA_W-1:0] value);
      burst_reg = value[CNT_W-1:0];
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] value);
      int unsigned count;
      int unsigned limit;
      int unsigned kept;
      if (taken == '0) begin
        lo = value;
        hi = value;
      end else begin
        if (value < lo) lo = value;
        if (value > hi) hi = value;
      end
      sum   = sum + SUM_W'(value);
      count = 32'(taken) + 1;
      limit = 32'(burst_reg);
      if (limit < MIN_BURST_LEN) limit = MIN_BURST_LEN;
      if (limit > MAX_SAMPLES_DEF) limit = MAX_SAMPLES_DEF;
      if (count < limit) begin
        taken = CNT_W'(count);
        return;
      end
      // the burst ends as soon as the count reaches or passes the length
      kept = 32'(sum) - 32'(lo) - 32'(hi);
      averages_due.push_back(SAMPLE_W'(kept / (count - TRIM_DROP)));
      sum   = '0;
      lo    = '0;
      hi    = '0;
      taken = '0;
    endfunction

    function void check_average(logic [TDATA_W-1:0] word);
      logic [SAMPLE_W-1:0] due;
      averages_checked++;
      if (word[TDATA_W-1:SAMPLE_W] !== '0) begin
        $error("tdata padding mismatch: expected 0, actual %0h", word[TDATA_W-1:SAMPLE_W]);
        errors++;
      end
      if (averages_due.size() == 0) begin
        $error("trimmed_average: transfer with nothing expected, actual %0d",
               word[SAMPLE_W-1:0]);
        errors++;
        return;
      end
      due = averages_due.pop_front();
      if (word[SAMPLE_W-1:0] !== due) begin
        $error("trimmed_average mismatch: expected %0d, actual %0d", due, word[SAMPLE_W-1:0]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;  // [16:0] sample, rest zero
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;        // [16:0] trimmed_average, rest zero

  burst_tracker        sb = new();
  bit                  steady = 1'b0;
  int                  samples_sent = 0;
  int                  length_writes = 0;
  logic [SAMPLE_W-1:0] last_sample = '0;

  trimmed_mean_sample_averager_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: pick_sample = '0;
      1: pick_sample = '1;
      2: pick_sample = SAMPLE_W'($urandom_range(0, 15));
      3: pick_sample = SAMPLE_W'((1 << SAMPLE_W) - 1 - $urandom_range(0, 15));
      4: pick_sample = last_sample;
      default: pick_sample = SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
    endcase
    last_sample = pick_sample;
  endfunction

  // entered at a falling edge, leaves at the falling edge after the transfer
  task automatic push_sample(input logic [SAMPLE_W-1:0] value);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(value);
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_sample(value);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                          output logic [APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_burst_reg();
    logic [APB_DATA_W-1:0] word;
    apb_read(ADDR_BURST_LEN, word);
    if (word !== APB_DATA_W'(sb.burst_reg)) begin
      $error("samples_per_average mismatch: expected %0d, actual %0d", sb.burst_reg, word);
      sb.errors++;
    end
  endtask

  task automatic set_burst_len(input logic [APB_DATA_W-1:0] value);
    apb_write(ADDR_BURST_LEN, value);
    sb.set_burst_reg(value);
    length_writes++;
    check_burst_reg();
  endtask

  // idle the sender until every average is out and the divider has gone quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.averages_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic push_burst(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                            input logic [SAMPLE_W-1:0] c);
    push_sample(a);
    push_sample(b);
    push_sample(c);
  endtask

  // receiver: random stalls plus a long hold-off after some averages
  initial begin : sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_average(m_axis_tdata);
        if (sb.averages_checked == 40 || sb.averages_checked == 160) hold_left = LONG_HOLD;
      end
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int random_start;
    int n;
    int r;
    logic [APB_DATA_W-1:0] len;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset length of 10, extremes mixed in
    check_burst_reg();
    push_burst('1, '0, 17'd7);
    push_burst(17'd9, 17'd11, 17'd13);
    push_burst(17'h10000, 17'd100, 17'd3);
    push_sample(17'd5);
    settle();

    // short lengths all act as 3
    set_burst_len(32'd0);
    push_burst('1, '1, '1);
    settle();
    set_burst_len(32'd2);
    push_burst('0, '0, '0);
    settle();
    set_burst_len(32'd1);
    push_burst(17'd5, '0, '1);
    settle();
    set_burst_len(32'd3);
    // a write to an unmapped word changes nothing
    apb_write(ADDR_UNMAPPED, 32'd7);
    check_burst_reg();
    push_burst(17'd100, 17'd50, 17'd75);
    settle();

    // shrink in mid-burst: the next sample ends it with count 16
    set_burst_len(32'hFFFF_FF14);
    repeat (15) push_sample(pick_sample());
    settle();
    set_burst_len(32'd4);
    push_sample(pick_sample());
    settle();
    // grow in mid-burst: the burst does not restart
    set_burst_len(32'd5);
    repeat (2) push_sample(pick_sample());
    settle();
    set_burst_len(32'd8);
    repeat (6) push_sample(pick_sample());
    settle();

    // longest burst at full scale
    steady = 1'b1;
    set_burst_len(32'd255);
    repeat (255) push_sample('1);
    settle();
    steady = 1'b0;

    random_start = samples_sent;
    while (samples_sent - random_start < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 19);
      if (r == 0) len = $urandom_range(0, 2);
      else if (r == 1) len = $urandom_range(100, 255);
      else if (r <= 3) len = $urandom_range(17, 60);
      else len = $urandom_range(3, 16);
      len[APB_DATA_W-1:CNT_W] = (APB_DATA_W-CNT_W)'($urandom);
      set_burst_len(len);
      n = $urandom_range(10, 60);
      repeat (n) push_sample(pick_sample());
      settle();
    end

    if (sb.averages_due.size() != 0) begin
      $error("trimmed_average: %0d results never arrived", sb.averages_due.size());
      sb.errors++;
    end
    $display("covered %0d samples and %0d trimmed averages across %0d burst-length writes",
             samples_sent, sb.averages_checked, length_writes);
    $display("lengths 0 to 255, mid-burst changes, stalls and a long output hold-off");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/tmsa_pkg.sv
rtl/core/trimmed_mean_sample_averager_core.sv
rtl/core/tmsa_checker.sv
tb/sv/trimmed_mean_sample_averager_core_tb.sv
